>>> rtl/core/tile_to_raster_address_gen_macros.svh
// Assertion macros used by the front end of the tiled-to-raster address generator.
`ifndef TILE_TO_RASTER_ADDRESS_GEN_MACROS_SVH
`define TILE_TO_RASTER_ADDRESS_GEN_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TTR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ttr: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TTR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ttr: next-cycle check failed");

`endif

>>> rtl/core/ttr_pkg.sv
// Package with widths, register indexes, types and helpers of the address generator.
package ttr_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;
  localparam int MAX_TILE   = 64;

  localparam int PIX_W    = 32;
  localparam int DIM_W    = 13;
  localparam int TILE_W   = 7;
  localparam int INTILE_W = 6;
  localparam int POS_W    = 12;
  localparam int COORD_W  = 13;
  localparam int ADDR_W   = 24;
  localparam int PROD_W   = 2 * DIM_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int STEP_W     = 4;

  localparam logic [DIM_W-1:0]  MAX_WIDTH_V  = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0]  MAX_HEIGHT_V = DIM_W'(MAX_HEIGHT);
  localparam logic [TILE_W-1:0] MAX_TILE_V   = TILE_W'(MAX_TILE);
  localparam logic [STEP_W-1:0] LAST_STEP    = STEP_W'(DIM_W - 1);

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_WIDTH   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_HEIGHT  = 2'd3;

  // Effective configuration as seen by the datapath.
  typedef struct packed {
    logic [DIM_W-1:0]  w;
    logic [DIM_W-1:0]  h;
    logic [TILE_W-1:0] tw;
    logic [TILE_W-1:0] th;
    logic              err;
    logic              busy;
  } cfg_t;

  // One classified pixel waiting for address generation.
  typedef struct packed {
    logic [PIX_W-1:0]   pixel;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               frame_last;
    logic               layout_error;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > maxv) begin
      r = maxv;
    end
    return r;
  endfunction

  function automatic logic [TILE_W-1:0] clamp_tile(input logic [TILE_W-1:0] v);
    logic [TILE_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = TILE_W'(1);
    end else if (v > MAX_TILE_V) begin
      r = MAX_TILE_V;
    end
    return r;
  endfunction

endpackage

>>> rtl/core/ttr_in_if.sv
// Input channel interface carrying tiled-order pixels.
interface ttr_in_if;
  logic                      valid;
  logic                      ready;
  logic [ttr_pkg::PIX_W-1:0] pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

>>> rtl/core/ttr_out_if.sv
// Result channel interface carrying pixels with their raster destination.
interface ttr_out_if;
  logic                       valid;
  logic                       ready;
  logic [ttr_pkg::PIX_W-1:0]  pixel_out;
  logic [ttr_pkg::POS_W-1:0]  dest_x;
  logic [ttr_pkg::POS_W-1:0]  dest_y;
  logic [ttr_pkg::ADDR_W-1:0] dest_address;
  logic                       frame_last;
  logic                       layout_error;

  modport source (output valid, output pixel_out, output dest_x, output dest_y,
                  output dest_address, output frame_last, output layout_error,
                  input ready);
  modport sink   (input valid, input pixel_out, input dest_x, input dest_y,
                  input dest_address, input frame_last, input layout_error,
                  output ready);
endinterface

>>> rtl/core/tile_to_raster_address_gen.sv
// Tiled-to-raster address generator: one pixel per cycle sustained while the output is ready
// and no configuration check runs, through a front end, a two-entry queue and an address
// stage with an output register. An accepted pixel is registered in the queue and then in
// the output register before it is valid. After any configuration write the input stalls
// while the 13-step serial remainder unit checks that the tile size divides the image size.
// Reset (synchronous, active low) restores 256 x 1 image, 1 x 1 tiles and zeroes the counters.
module tile_to_raster_address_gen (
  input  logic                            clk,
  input  logic                            rst_n,
  ttr_in_if.sink                          in_chan,
  ttr_out_if.source                       out_chan,
  input  logic                            cfg_we,
  input  logic [ttr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ttr_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  ttr_pkg::cfg_t    cfg;
  ttr_pkg::q_stat_t q_stat;
  ttr_pkg::entry_t  push_entry, head;
  logic             push, pop;

  ttr_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ttr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .cfg        (cfg),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  ttr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_stat     (q_stat)
  );

  ttr_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .q_stat   (q_stat),
    .width    (cfg.w),
    .pop      (pop),
    .out_chan (out_chan)
  );

endmodule

>>> rtl/core/ttr_cfg.sv
// Configuration registers, range clamping and the serial tile divisibility check.
module ttr_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [ttr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ttr_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output ttr_pkg::cfg_t                    cfg
);

  logic [ttr_pkg::DIM_W-1:0]  iw_r, ih_r;
  logic [ttr_pkg::TILE_W-1:0] tw_r, th_r;
  logic [ttr_pkg::DIM_W-1:0]  w_c, h_c;
  logic [ttr_pkg::TILE_W-1:0] tw_c, th_c;

  logic                       busy_r, busy_nxt;
  logic                       load_r, load_nxt;
  logic                       err_r, err_nxt;
  logic [ttr_pkg::STEP_W-1:0] step_r, step_nxt;
  logic [ttr_pkg::DIM_W-1:0]  shw_r, shw_nxt, shh_r, shh_nxt;
  logic [ttr_pkg::TILE_W-1:0] remw_r, remw_nxt, remh_r, remh_nxt;
  logic [ttr_pkg::TILE_W-1:0] remw_sh, remh_sh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iw_r <= ttr_pkg::DIM_W'(256);
      ih_r <= ttr_pkg::DIM_W'(1);
      tw_r <= ttr_pkg::TILE_W'(1);
      th_r <= ttr_pkg::TILE_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        ttr_pkg::REG_IMAGE_WIDTH:  iw_r <= cfg_wdata;
        ttr_pkg::REG_IMAGE_HEIGHT: ih_r <= cfg_wdata;
        ttr_pkg::REG_TILE_WIDTH:   tw_r <= cfg_wdata[ttr_pkg::TILE_W-1:0];
        ttr_pkg::REG_TILE_HEIGHT:  th_r <= cfg_wdata[ttr_pkg::TILE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign w_c  = ttr_pkg::clamp_dim(iw_r, ttr_pkg::MAX_WIDTH_V);
  assign h_c  = ttr_pkg::clamp_dim(ih_r, ttr_pkg::MAX_HEIGHT_V);
  assign tw_c = ttr_pkg::clamp_tile(tw_r);
  assign th_c = ttr_pkg::clamp_tile(th_r);

  // Restoring remainder, one dividend bit per cycle for width and height together.
  assign remw_sh = {remw_r[ttr_pkg::TILE_W-2:0], shw_r[ttr_pkg::DIM_W-1]};
  assign remh_sh = {remh_r[ttr_pkg::TILE_W-2:0], shh_r[ttr_pkg::DIM_W-1]};

  always_comb begin
    busy_nxt = busy_r;
    load_nxt = 1'b0;
    err_nxt  = err_r;
    step_nxt = step_r;
    shw_nxt  = shw_r;
    shh_nxt  = shh_r;
    remw_nxt = remw_r;
    remh_nxt = remh_r;
    if (cfg_we) begin
      busy_nxt = 1'b1;
      load_nxt = 1'b1;
    end else if (load_r) begin
      shw_nxt  = w_c;
      shh_nxt  = h_c;
      remw_nxt = '0;
      remh_nxt = '0;
      step_nxt = '0;
    end else if (busy_r) begin
      remw_nxt = (remw_sh >= tw_c) ? remw_sh - tw_c : remw_sh;
      remh_nxt = (remh_sh >= th_c) ? remh_sh - th_c : remh_sh;
      shw_nxt  = {shw_r[ttr_pkg::DIM_W-2:0], 1'b0};
      shh_nxt  = {shh_r[ttr_pkg::DIM_W-2:0], 1'b0};
      step_nxt = step_r + 1'b1;
      if (step_r == ttr_pkg::LAST_STEP) begin
        busy_nxt = 1'b0;
        err_nxt  = (remw_nxt != '0) || (remh_nxt != '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      load_r <= 1'b0;
      err_r  <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      load_r <= load_nxt;
      err_r  <= err_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shw_r  <= shw_nxt;
    shh_r  <= shh_nxt;
    remw_r <= remw_nxt;
    remh_r <= remh_nxt;
  end

  assign cfg.w    = w_c;
  assign cfg.h    = h_c;
  assign cfg.tw   = tw_c;
  assign cfg.th   = th_c;
  assign cfg.err  = err_r;
  assign cfg.busy = busy_r;

endmodule

>>> rtl/core/ttr_front.sv
// Front end: accepts pixels, walks the tile counters and classifies each pixel.
`include "tile_to_raster_address_gen_macros.svh"

module ttr_front (
  input  logic                 clk,
  input  logic                 rst_n,
  ttr_in_if.sink               in_chan,
  input  ttr_pkg::cfg_t        cfg,
  input  ttr_pkg::q_stat_t     q_stat,
  output logic                 push,
  output ttr_pkg::entry_t      push_entry
);

  logic [ttr_pkg::INTILE_W-1:0] col_r, col_nxt, row_r, row_nxt;
  logic [ttr_pkg::POS_W-1:0]    tlx_r, tlx_nxt, sty_r, sty_nxt;
  logic [ttr_pkg::COORD_W-1:0]  x_c, y_c;
  logic [ttr_pkg::COORD_W-1:0]  tile_end, strip_end;
  logic [ttr_pkg::TILE_W-1:0]   col_inc, row_inc;
  logic                         end_col, end_row, end_tile, end_strip;
  logic                         accept, last_c;

  assign in_chan.ready = !cfg.busy && !q_stat.full;
  assign accept        = in_chan.valid && in_chan.ready;

  assign x_c = {1'b0, tlx_r} + ttr_pkg::COORD_W'(col_r);
  assign y_c = {1'b0, sty_r} + ttr_pkg::COORD_W'(row_r);

  assign col_inc   = {1'b0, col_r} + 1'b1;
  assign row_inc   = {1'b0, row_r} + 1'b1;
  assign tile_end  = {1'b0, tlx_r} + ttr_pkg::COORD_W'(cfg.tw);
  assign strip_end = {1'b0, sty_r} + ttr_pkg::COORD_W'(cfg.th);

  assign end_col   = col_inc >= cfg.tw;
  assign end_row   = row_inc >= cfg.th;
  assign end_tile  = tile_end >= cfg.w;
  assign end_strip = strip_end >= cfg.h;
  assign last_c    = end_col && end_row && end_tile && end_strip;

  // A layout error zeroes the coordinates and leaves the counters where they are.
  always_comb begin
    push_entry.pixel        = in_chan.pixel_in;
    push_entry.x            = cfg.err ? '0 : x_c;
    push_entry.y            = cfg.err ? '0 : y_c;
    push_entry.frame_last   = !cfg.err && last_c;
    push_entry.layout_error = cfg.err;
  end

  assign push = accept;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    tlx_nxt = tlx_r;
    sty_nxt = sty_r;
    if (accept && !cfg.err) begin
      if (!end_col) begin
        col_nxt = col_inc[ttr_pkg::INTILE_W-1:0];
      end else begin
        col_nxt = '0;
        if (!end_row) begin
          row_nxt = row_inc[ttr_pkg::INTILE_W-1:0];
        end else begin
          row_nxt = '0;
          if (!end_tile) begin
            tlx_nxt = tile_end[ttr_pkg::POS_W-1:0];
          end else begin
            tlx_nxt = '0;
            sty_nxt = end_strip ? '0 : strip_end[ttr_pkg::POS_W-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      tlx_r <= '0;
      sty_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      tlx_r <= tlx_nxt;
      sty_r <= sty_nxt;
    end
  end

  `TTR_ASSERT_NEXT(a_hold_on_error, clk, rst_n, accept && cfg.err, $stable(col_r) && $stable(row_r) && $stable(tlx_r) && $stable(sty_r))
  `TTR_ASSERT_NEXT(a_wrap_after_last, clk, rst_n, accept && push_entry.frame_last, col_r == '0 && row_r == '0 && tlx_r == '0 && sty_r == '0)
  `TTR_ASSERT_NEXT(a_next_tile, clk, rst_n, accept && !cfg.err && end_col && end_row && !end_tile, tlx_r == ttr_pkg::POS_W'($past(tlx_r) + $past(cfg.tw)) && col_r == '0)

endmodule

>>> rtl/core/ttr_queue.sv
// Two-entry queue between the classifying front end and the address back end.
module ttr_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  ttr_pkg::entry_t      push_entry,
  input  logic                 pop,
  output ttr_pkg::entry_t      head,
  output ttr_pkg::q_stat_t     q_stat
);

  ttr_pkg::entry_t mem_r [2];
  logic            wp_r, rp_r;
  logic [1:0]      cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign do_push = push && (cnt_r != 2'd2);
  assign do_pop  = pop && (cnt_r != 2'd0);

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wp_r <= !wp_r;
      end
      if (do_pop) begin
        rp_r <= !rp_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_entry;
    end
  end

  assign head         = mem_r[rp_r];
  assign q_stat.full  = cnt_r == 2'd2;
  assign q_stat.empty = cnt_r == 2'd0;

endmodule

>>> rtl/core/ttr_back.sv
// Back end: forms the linear address and holds the result in the output register.
module ttr_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ttr_pkg::entry_t            head,
  input  ttr_pkg::q_stat_t           q_stat,
  input  logic [ttr_pkg::DIM_W-1:0]  width,
  output logic                       pop,
  ttr_out_if.source                  out_chan
);

  logic                        valid_r;
  logic [ttr_pkg::PIX_W-1:0]   pixel_r;
  logic [ttr_pkg::POS_W-1:0]   x_r, y_r;
  logic [ttr_pkg::ADDR_W-1:0]  addr_r;
  logic                        last_r, err_r;
  logic [ttr_pkg::PROD_W-1:0]  prod_c, sum_c;

  assign prod_c = head.y * width;
  assign sum_c  = prod_c + ttr_pkg::PROD_W'(head.x);

  assign pop = !q_stat.empty && (!valid_r || out_chan.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      pixel_r <= head.pixel;
      x_r     <= head.x[ttr_pkg::POS_W-1:0];
      y_r     <= head.y[ttr_pkg::POS_W-1:0];
      addr_r  <= sum_c[ttr_pkg::ADDR_W-1:0];
      last_r  <= head.frame_last;
      err_r   <= head.layout_error;
    end
  end

  assign out_chan.valid        = valid_r;
  assign out_chan.pixel_out    = pixel_r;
  assign out_chan.dest_x       = x_r;
  assign out_chan.dest_y       = y_r;
  assign out_chan.dest_address = addr_r;
  assign out_chan.frame_last   = last_r;
  assign out_chan.layout_error = err_r;

endmodule

>>> dv/tile_to_raster_address_gen_test.sv
// Testbench that checks the tiled-to-raster address generator against its own pixel predictor.
`timescale 1ns / 100ps

module tile_to_raster_address_gen_test;
  import ttr_pkg::*;

  localparam int HALF_PERIOD = 5;
  localparam int RESET_CYCLES = 9;
  localparam int CYCLE_LIMIT = 600000;
  localparam int TAIL_CYCLES = 16;
  localparam int RANDOM_ITEMS = 800;
  localparam int STREAM_ITEMS = 150;

  // Expected contents of one output transaction.
  typedef struct packed {
    logic [PIX_W-1:0]  pixel;
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
    logic [ADDR_W-1:0] addr;
    logic              last;
    logic              err;
  } raster_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  ttr_in_if  in_chan();
  ttr_out_if out_chan();

  tile_to_raster_address_gen dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Predictor copy of the registers and the position counters.
  logic [DIM_W-1:0]  image_w_reg;
  logic [DIM_W-1:0]  image_h_reg;
  logic [TILE_W-1:0] tile_w_reg;
  logic [TILE_W-1:0] tile_h_reg;
  int unsigned       pos_col;
  int unsigned       pos_row;
  int unsigned       tile_x0;
  int unsigned       strip_y0;

  raster_result_t pending_pixels[$];
  int unsigned    mismatches;
  int unsigned    results_seen;
  int unsigned    pixels_sent;
  int unsigned    cycle_count;
  bit             gaps_on;
  bit             stalls_on;

  initial begin
    clk = 1'b0;
  end

  always #(HALF_PERIOD) clk = ~clk;

  function automatic int unsigned effective(input int unsigned v, input int unsigned ceiling);
    if (v == 0) return 1;
    if (v > ceiling) return ceiling;
    return v;
  endfunction

  // Computes the destination of one pixel and, for a valid layout, advances the tile walk.
  function automatic raster_result_t map_pixel(input logic [PIX_W-1:0] pix);
    int unsigned w;
    int unsigned h;
    int unsigned tw;
    int unsigned th;
    longint unsigned x;
    longint unsigned y;
    longint unsigned a;
    bit end_col;
    bit end_row;
    bit end_tile;
    bit end_strip;
    raster_result_t r;
    w = effective(image_w_reg, MAX_WIDTH);
    h = effective(image_h_reg, MAX_HEIGHT);
    tw = effective(tile_w_reg, MAX_TILE);
    th = effective(tile_h_reg, MAX_TILE);
    r = '0;
    r.pixel = pix;
    // A tile size that does not divide the image flags the pixel and freezes the walk.
    if ((w % tw) != 0 || (h % th) != 0) begin
      r.err = 1'b1;
      return r;
    end
    x = tile_x0 + pos_col;
    y = strip_y0 + pos_row;
    a = y * w + x;
    end_col = (pos_col + 1) >= tw;
    end_row = (pos_row + 1) >= th;
    end_tile = (tile_x0 + tw) >= w;
    end_strip = (strip_y0 + th) >= h;
    r.x = POS_W'(x);
    r.y = POS_W'(y);
    r.addr = ADDR_W'(a);
    r.last = end_col && end_row && end_tile && end_strip;
    if (!end_col) begin
      pos_col = (pos_col + 1) % (2 ** INTILE_W);
    end else begin
      pos_col = 0;
      if (!end_row) begin
        pos_row = (pos_row + 1) % (2 ** INTILE_W);
      end else begin
        pos_row = 0;
        if (!end_tile) begin
          tile_x0 = (tile_x0 + tw) % (2 ** POS_W);
        end else begin
          tile_x0 = 0;
          if (!end_strip) begin
            strip_y0 = (strip_y0 + th) % (2 ** POS_W);
          end else begin
            strip_y0 = 0;
          end
        end
      end
    end
    return r;
  endfunction

  // Register writes, accepted pixels and finished results, all seen at the rising edge.
  always @(posedge clk) begin
    raster_result_t got;
    raster_result_t want;
    if (!rst_n) begin
      image_w_reg = DIM_W'(256);
      image_h_reg = DIM_W'(1);
      tile_w_reg = TILE_W'(1);
      tile_h_reg = TILE_W'(1);
      pos_col = 0;
      pos_row = 0;
      tile_x0 = 0;
      strip_y0 = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_IMAGE_WIDTH: begin
            image_w_reg = cfg_wdata[DIM_W-1:0];
          end
          REG_IMAGE_HEIGHT: begin
            image_h_reg = cfg_wdata[DIM_W-1:0];
          end
          REG_TILE_WIDTH: begin
            tile_w_reg = cfg_wdata[TILE_W-1:0];
          end
          REG_TILE_HEIGHT: begin
            tile_h_reg = cfg_wdata[TILE_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (in_chan.valid && in_chan.ready) begin
        pending_pixels.push_back(map_pixel(in_chan.pixel_in));
      end
      if (out_chan.valid && out_chan.ready) begin
        got.pixel = out_chan.pixel_out;
        got.x = out_chan.dest_x;
        got.y = out_chan.dest_y;
        got.addr = out_chan.dest_address;
        got.last = out_chan.frame_last;
        got.err = out_chan.layout_error;
        results_seen++;
        if (pending_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result %0d arrived with no pending pixel: pixel %h x %0d y %0d addr %h",
                     results_seen, got.pixel, got.x, got.y, got.addr);
          end
        end else begin
          want = pending_pixels.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch on result %0d", results_seen);
              $display("  expected pixel %h x %0d y %0d addr %h last %b err %b",
                       want.pixel, want.x, want.y, want.addr, want.last, want.err);
              $display("  actual   pixel %h x %0d y %0d addr %h last %b err %b",
                       got.pixel, got.x, got.y, got.addr, got.last, got.err);
            end
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result side back-pressure in random bursts.
  initial begin
    int unsigned burst;
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stalls_on && $urandom_range(0, 5) == 0) begin
        out_chan.ready <= 1'b0;
        burst = $urandom_range(1, 14);
        repeat (burst) @(negedge clk);
      end
      out_chan.ready <= 1'b1;
    end
  end

  // Every task is entered and left just after a falling edge.
  task automatic send_pixel(input logic [PIX_W-1:0] pix);
    int unsigned gap;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_chan.valid <= 1'b0;
      gap = $urandom_range(1, 14);
      repeat (gap) @(negedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.pixel_in <= pix;
    do @(posedge clk); while (!in_chan.ready);
    @(negedge clk);
    pixels_sent++;
  endtask

  // Holds the input idle until every accepted pixel has come back.
  task automatic drain();
    in_chan.valid <= 1'b0;
    do @(negedge clk); while (pending_pixels.size() != 0);
  endtask

  task automatic program_regs(input int unsigned w, input int unsigned h,
                              input int unsigned tw, input int unsigned th);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_wdata <= CFG_DATA_W'(w);
    @(negedge clk);
    cfg_index <= REG_IMAGE_HEIGHT;
    cfg_wdata <= CFG_DATA_W'(h);
    @(negedge clk);
    cfg_index <= REG_TILE_WIDTH;
    cfg_wdata <= CFG_DATA_W'(tw);
    @(negedge clk);
    cfg_index <= REG_TILE_HEIGHT;
    cfg_wdata <= CFG_DATA_W'(th);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic pick_config(output int unsigned w, output int unsigned h,
                             output int unsigned tw, output int unsigned th,
                             output int unsigned count);
    int unsigned kind;
    kind = $urandom_range(0, 9);
    tw = $urandom_range(1, 8);
    th = $urandom_range(1, 8);
    w = tw * $urandom_range(1, 6);
    h = th * $urandom_range(1, 4);
    count = $urandom_range(10, 70);
    case (kind)
      6: begin
        // Width or height that the tile does not divide.
        tw = $urandom_range(2, 8);
        th = $urandom_range(2, 8);
        if ($urandom_range(0, 1) == 0) begin
          w = tw * $urandom_range(0, 5) + $urandom_range(1, tw - 1);
        end else begin
          h = th * $urandom_range(0, 3) + $urandom_range(1, th - 1);
        end
        count = $urandom_range(5, 20);
      end
      7: begin
        // Zero and over-range values that clamp to a legal layout.
        tw = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(64, 127);
        th = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(64, 127);
        w = $urandom_range(4096, 8191);
        h = $urandom_range(4096, 8191);
        count = $urandom_range(5, 30);
      end
      8: begin
        tw = 2 ** $urandom_range(0, 6);
        th = 2 ** $urandom_range(0, 6);
        w = 4096;
        h = 4096;
        count = $urandom_range(5, 30);
      end
      9: begin
        w = $urandom_range(0, 8191);
        h = $urandom_range(0, 8191);
        tw = $urandom_range(0, 8191);
        th = $urandom_range(0, 8191);
        count = $urandom_range(5, 20);
      end
      default: begin
        // Often run past the end of the frame to see the wrap.
        if ($urandom_range(0, 2) == 0) begin
          count = w * h + $urandom_range(1, 10);
        end
      end
    endcase
  endtask

  task automatic test_reset_layout();
    send_pixel(32'h0000_0000);
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'hA5A5_A5A5);
    send_pixel(32'h5A5A_5A5A);
    send_pixel(32'h8000_0001);
  endtask

  task automatic test_register_extremes();
    int unsigned i;
    program_regs(4096, 4096, 64, 64);
    repeat (3) send_pixel($urandom());
    // Over-range values clamp; the walk carries on from where it stood.
    program_regs(8191, 4096, 127, 64);
    repeat (2) send_pixel($urandom());
    // Zeros act as a one-pixel image, so the stale column wraps at once.
    program_regs(0, 0, 0, 0);
    repeat (2) send_pixel($urandom());
    program_regs(7, 4, 2, 2);
    repeat (2) send_pixel($urandom());
    program_regs(4, 3, 2, 2);
    send_pixel($urandom());
    program_regs(4, 2, 2, 2);
    for (i = 0; i < 9; i++) begin
      send_pixel($urandom());
    end
  endtask

  task automatic test_random_layouts(input int unsigned target);
    int unsigned w;
    int unsigned h;
    int unsigned tw;
    int unsigned th;
    int unsigned count;
    int unsigned start;
    bit paused;
    start = pixels_sent;
    paused = 1'b0;
    while (pixels_sent - start < target) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
      pick_config(w, h, tw, th, count);
      program_regs(w, h, tw, th);
      repeat (count) begin
        send_pixel($urandom());
        if (!paused && pixels_sent - start >= target / 2) begin
          paused = 1'b1;
          drain();
        end
      end
    end
  endtask

  task automatic test_back_to_back(input int unsigned target);
    int unsigned w;
    int unsigned h;
    int unsigned tw;
    int unsigned th;
    int unsigned count;
    int unsigned start;
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    start = pixels_sent;
    while (pixels_sent - start < target) begin
      pick_config(w, h, tw, th, count);
      program_regs(w, h, tw, th);
      repeat (count) send_pixel($urandom());
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_IMAGE_WIDTH;
    cfg_wdata = '0;
    in_chan.valid = 1'b0;
    in_chan.pixel_in = '0;
    mismatches = 0;
    results_seen = 0;
    pixels_sent = 0;
    cycle_count = 0;
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_layout();
    test_register_extremes();
    test_random_layouts(RANDOM_ITEMS);
    test_back_to_back(STREAM_ITEMS);

    drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/ttr_pkg.sv
rtl/core/ttr_in_if.sv
rtl/core/ttr_out_if.sv
rtl/core/ttr_cfg.sv
rtl/core/ttr_front.sv
rtl/core/ttr_queue.sv
rtl/core/ttr_back.sv
rtl/core/tile_to_raster_address_gen.sv
dv/tile_to_raster_address_gen_test.sv
